FILE: src/apf_pkg.sv
`timescale 1ns / 1ps
// Package: widths, state encoding and helpers for the articulation point finder.
package apf_pkg;
    localparam int MaxNodes  = 64;
    localparam int MaxEdges  = 256;
    localparam int NodeW     = 7;
    localparam int EdgeAw    = $clog2(MaxEdges);
    localparam int EdgeCntW  = EdgeAw + 1;
    localparam int NodeAw    = $clog2(MaxNodes);
    localparam int DepthW    = NodeAw + 1;
    localparam int TimeW     = 6;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP_WAIT,
        ST_NEXT_ROOT,
        ST_FRAME,
        ST_EDGE_RD,
        ST_EDGE,
        ST_POP,
        ST_POP2,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [NodeW-1:0] end_a;
        logic [NodeW-1:0] end_b;
    } edge_t;

    typedef struct packed {
        logic [NodeW-1:0]    node;
        logic [NodeW-1:0]    parent;
        logic [EdgeCntW-1:0] cursor;
    } frame_t;

    // Clamp the node count register to the usable range.
    function automatic logic [NodeW-1:0] active_nodes(input logic [NodeW-1:0] cnt);
        logic [NodeW-1:0] r;
        r = cnt;
        if (cnt == '0)
            r = NodeW'(1);
        else if (cnt > NodeW'(MaxNodes))
            r = NodeW'(MaxNodes);
        return r;
    endfunction
endpackage

FILE: src/apf_if.sv
`timescale 1ns / 1ps
// Interfaces: edge input channel and node result channel.
interface apf_in_if;
    logic                      valid;
    logic                      ready;
    logic                      has_edge;
    logic [apf_pkg::NodeW-1:0] end_a;
    logic [apf_pkg::NodeW-1:0] end_b;
    logic                      last_edge;
    modport source (output valid, has_edge, end_a, end_b, last_edge, input ready);
    modport sink   (input valid, has_edge, end_a, end_b, last_edge, output ready);
endinterface

interface apf_out_if;
    logic                      valid;
    logic                      ready;
    logic [apf_pkg::NodeW-1:0] node_id;
    logic                      is_cut;
    logic                      edges_dropped;
    logic                      last_result;
    modport source (output valid, node_id, is_cut, edges_dropped, last_result, input ready);
    modport sink   (input valid, node_id, is_cut, edges_dropped, last_result, output ready);
endinterface

FILE: src/articulation_point_finder.sv
`timescale 1ns / 1ps
// Top level: edge store, search sequencer and result stream.
// Edge beats load one per cycle (ready held high while loading). The beat with
// last_edge set starts the search, and in.ready stays low until the last result
// beat is taken. Every visited node scans the whole edge store once through one
// read port: each stored edge passes ST_FRAME and ST_EDGE_RD, and ST_EDGE too
// if it leads to an in-range node other than the parent; the frame then pops
// through ST_POP, ST_POP_WAIT and ST_POP2 (only ST_POP for a search root), and
// ST_NEXT_ROOT steps one node number at a time to pick roots. Results then
// stream at one beat per cycle, node 1 upward, stretched by any out.ready stall.
module articulation_point_finder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [apf_pkg::NodeW-1:0]   cfg_wdata,
    apf_in_if.sink                      in_ch,
    apf_out_if.source                   out_ch
);
    import apf_pkg::*;

    // storage
    edge_t            edge_mem [MaxEdges];
    logic [TimeW-1:0] entry_mem [MaxNodes];
    logic [TimeW-1:0] low_mem   [MaxNodes];
    frame_t           stack_mem [MaxNodes];
    logic [MaxNodes-1:0] visited_reg, visited_next;
    logic [MaxNodes-1:0] cut_reg, cut_next;

    state_t state_reg, state_next;
    logic [NodeW-1:0]    ncfg_reg;
    logic [EdgeCntW-1:0] etotal_reg, etotal_next;
    logic                drop_reg, drop_next;
    logic [NodeW-1:0]    clock_reg, clock_next;
    logic [NodeW-1:0]    rchild_reg, rchild_next;
    logic [DepthW-1:0]   depth_reg, depth_next;
    logic [NodeW-1:0]    root_reg, root_next;
    logic [NodeW-1:0]    n_reg, n_next;
    frame_t              top_reg, top_next;
    logic [TimeW-1:0]    ulow_reg, ulow_next;
    edge_t               erd_reg;
    logic [TimeW-1:0]    oentry_reg;
    logic [NodeW-1:0]    other_reg, other_next;
    logic [NodeW-1:0]    emit_reg, emit_next;

    // write controls
    logic               push_en, low_wr, entry_wr;
    logic [NodeAw-1:0]  push_idx;
    frame_t             push_frame;
    logic [NodeAw-1:0]  low_idx, entry_idx;
    logic [TimeW-1:0]   low_val, entry_val;
    frame_t             stack_rd_reg;
    logic [TimeW-1:0]   plow_reg, pentry_reg;

    logic [NodeW-1:0] n_now;
    logic             accept, edge_ok;
    assign n_now  = active_nodes(ncfg_reg);
    assign accept = in_ch.valid && in_ch.ready;
    assign edge_ok = (in_ch.end_a != '0) && (in_ch.end_a <= n_now) &&
                     (in_ch.end_b != '0) && (in_ch.end_b <= n_now) &&
                     (etotal_reg < EdgeCntW'(MaxEdges));

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ncfg_reg <= NodeW'(MaxNodes);
        else if (cfg_we)
            ncfg_reg <= cfg_wdata;
    end

    // edge store write and scan read
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.has_edge && edge_ok)
            edge_mem[etotal_reg[EdgeAw-1:0]] <= '{end_a: in_ch.end_a, end_b: in_ch.end_b};
        erd_reg <= edge_mem[top_reg.cursor[EdgeAw-1:0]];
    end

    // node tables and stack; parent times are read from the registered frame
    always_ff @(posedge clk)
    begin
        if (entry_wr)
            entry_mem[entry_idx] <= entry_val;
        if (low_wr)
            low_mem[low_idx] <= low_val;
        if (push_en)
            stack_mem[push_idx] <= push_frame;
        oentry_reg   <= entry_mem[other_next[NodeAw-1:0] - NodeAw'(1)];
        stack_rd_reg <= stack_mem[depth_next[NodeAw-1:0] - NodeAw'(1)];
        plow_reg     <= low_mem[stack_rd_reg.node[NodeAw-1:0] - NodeAw'(1)];
        pentry_reg   <= entry_mem[stack_rd_reg.node[NodeAw-1:0] - NodeAw'(1)];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            etotal_reg  <= '0;
            drop_reg    <= 1'b0;
            visited_reg <= '0;
            cut_reg     <= '0;
            clock_reg   <= '0;
            rchild_reg  <= '0;
            depth_reg   <= '0;
            root_reg    <= '0;
            n_reg       <= '0;
            emit_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            etotal_reg  <= etotal_next;
            drop_reg    <= drop_next;
            visited_reg <= visited_next;
            cut_reg     <= cut_next;
            clock_reg   <= clock_next;
            rchild_reg  <= rchild_next;
            depth_reg   <= depth_next;
            root_reg    <= root_next;
            n_reg       <= n_next;
            emit_reg    <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        ulow_reg   <= ulow_next;
        other_reg  <= other_next;
    end

    logic [NodeW-1:0] u_node, cand;
    logic             hit;
    logic [TimeW-1:0] newlow;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        etotal_next  = etotal_reg;
        drop_next    = drop_reg;
        visited_next = visited_reg;
        cut_next     = cut_reg;
        clock_next   = clock_reg;
        rchild_next  = rchild_reg;
        depth_next   = depth_reg;
        root_next    = root_reg;
        n_next       = n_reg;
        emit_next    = emit_reg;
        top_next     = top_reg;
        ulow_next    = ulow_reg;
        other_next   = other_reg;
        push_en      = 1'b0;
        push_idx     = depth_reg[NodeAw-1:0];
        push_frame   = top_reg;
        low_wr       = 1'b0;
        entry_wr     = 1'b0;
        low_idx      = '0;
        entry_idx    = '0;
        low_val      = '0;
        entry_val    = '0;
        in_ch.ready  = 1'b0;
        u_node       = top_reg.node;
        cand         = '0;
        hit          = 1'b0;
        newlow       = ulow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ch.ready = 1'b1;
                if (accept)
                begin
                    if (in_ch.has_edge)
                    begin
                        if (edge_ok)
                            etotal_next = etotal_reg + EdgeCntW'(1);
                        else
                            drop_next = 1'b1;
                    end
                    if (in_ch.last_edge)
                    begin
                        n_next       = n_now;
                        visited_next = '0;
                        cut_next     = '0;
                        clock_next   = '0;
                        root_next    = NodeW'(1);
                        state_next   = ST_NEXT_ROOT;
                    end
                end
            end
            ST_NEXT_ROOT:
            begin
                if (root_reg > n_reg)
                begin
                    emit_next  = NodeW'(1);
                    state_next = ST_EMIT;
                end
                else if (visited_reg[root_reg[NodeAw-1:0] - NodeAw'(1)])
                    root_next = root_reg + NodeW'(1);
                else
                begin
                    // enter the root
                    visited_next[root_reg[NodeAw-1:0] - NodeAw'(1)] = 1'b1;
                    entry_wr    = 1'b1;
                    entry_idx   = root_reg[NodeAw-1:0] - NodeAw'(1);
                    entry_val   = clock_reg[TimeW-1:0];
                    ulow_next   = clock_reg[TimeW-1:0];
                    clock_next  = clock_reg + NodeW'(1);
                    rchild_next = '0;
                    depth_next  = DepthW'(1);
                    top_next    = '{node: root_reg, parent: '0, cursor: '0};
                    state_next  = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (top_reg.cursor >= etotal_reg)
                    state_next = ST_POP;
                else
                    state_next = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                // pick the far end of the edge, if this edge touches the node
                if (erd_reg.end_a == u_node)
                begin
                    cand = erd_reg.end_b;
                    hit  = 1'b1;
                end
                else if (erd_reg.end_b == u_node)
                begin
                    cand = erd_reg.end_a;
                    hit  = 1'b1;
                end
                if (cand == '0 || cand > n_reg || cand == top_reg.parent)
                    hit = 1'b0;
                other_next = cand;
                if (hit)
                    state_next = ST_EDGE;
                else
                begin
                    top_next.cursor = top_reg.cursor + EdgeCntW'(1);
                    state_next = ST_FRAME;
                end
            end
            ST_EDGE:
            begin
                top_next.cursor = top_reg.cursor + EdgeCntW'(1);
                if (!visited_reg[other_reg[NodeAw-1:0] - NodeAw'(1)])
                begin
                    if (depth_reg < DepthW'(MaxNodes))
                    begin
                        // save the current frame and descend
                        push_en    = 1'b1;
                        push_idx   = depth_reg[NodeAw-1:0] - NodeAw'(1);
                        push_frame = top_next;
                        low_wr     = 1'b1;
                        low_idx    = u_node[NodeAw-1:0] - NodeAw'(1);
                        low_val    = ulow_reg;
                        visited_next[other_reg[NodeAw-1:0] - NodeAw'(1)] = 1'b1;
                        entry_wr    = 1'b1;
                        entry_idx   = other_reg[NodeAw-1:0] - NodeAw'(1);
                        entry_val   = clock_reg[TimeW-1:0];
                        ulow_next   = clock_reg[TimeW-1:0];
                        clock_next  = clock_reg + NodeW'(1);
                        depth_next  = depth_reg + DepthW'(1);
                        top_next    = '{node: other_reg, parent: u_node, cursor: '0};
                    end
                end
                else if (oentry_reg < ulow_reg)
                    ulow_next = oentry_reg;
                state_next = ST_FRAME;
            end
            ST_POP:
            begin
                // record this node's low and fetch the parent frame
                low_wr     = 1'b1;
                low_idx    = u_node[NodeAw-1:0] - NodeAw'(1);
                low_val    = ulow_reg;
                depth_next = depth_reg - DepthW'(1);
                if (depth_reg == DepthW'(1))
                begin
                    if (rchild_reg > NodeW'(1))
                        cut_next[root_reg[NodeAw-1:0] - NodeAw'(1)] = 1'b1;
                    root_next  = root_reg + NodeW'(1);
                    state_next = ST_NEXT_ROOT;
                end
                else
                    state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
                // wait for the parent's times
                state_next = ST_POP2;
            ST_POP2:
            begin
                newlow = (ulow_reg < plow_reg) ? ulow_reg : plow_reg;
                if (stack_rd_reg.parent != '0)
                begin
                    if (ulow_reg >= pentry_reg)
                        cut_next[stack_rd_reg.node[NodeAw-1:0] - NodeAw'(1)] = 1'b1;
                end
                else
                    rchild_next = rchild_reg + NodeW'(1);
                top_next    = stack_rd_reg;
                ulow_next   = newlow;
                state_next  = ST_FRAME;
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    emit_next = emit_reg + NodeW'(1);
                    if (emit_reg == n_reg)
                    begin
                        etotal_next = '0;
                        drop_next   = 1'b0;
                        state_next  = ST_LOAD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // result beat
    assign out_ch.valid         = (state_reg == ST_EMIT);
    assign out_ch.node_id       = emit_reg;
    assign out_ch.is_cut        = cut_reg[emit_reg[NodeAw-1:0] - NodeAw'(1)];
    assign out_ch.edges_dropped = drop_reg;
    assign out_ch.last_result   = (emit_reg == n_reg);

    // checks
    a_no_ready_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !in_ch.ready) else $error("ready during search");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DepthW'(MaxNodes)) else $error("stack overflow");
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (emit_reg != '0 && emit_reg <= n_reg)) else $error("bad node id");
    a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_result) |=> (state_reg == ST_LOAD))
        else $error("no return to load");
endmodule
